// ----- hw/rtl/btts_pkg.sv -----
// Shared types and constants for the BER-TLV tag search unit.
// No dependencies; imported by ber_tlv_tag_search_unit.
package btts_pkg;

    // byte offsets wrap modulo 2**OFFSET_BITS (legal range 8 to 32)
    localparam int OFFSET_BITS    = 32;
    localparam int MATCH_OFFSET_W = 32;

    localparam int TAG_W       = 16;
    localparam int OCC_W       = 8;
    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 16;
    localparam int VLEN_W      = 32;

    // register indexes on the configuration port
    localparam logic [CFG_INDEX_W-1:0] CFG_TARGET_TAG        = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_WANTED_OCCURRENCE = 8'd1;

    // tag and length byte codes
    localparam logic [4:0] TAG_MULTI_BYTE  = 5'h1F;
    localparam logic [7:0] LEN_SHORT_LIMIT = 8'h80;
    localparam logic [7:0] LEN_LONG_MIN    = 8'h81;
    localparam logic [7:0] LEN_LONG_MAX    = 8'h84;

    typedef enum logic [1:0] {
        ST_FOUND     = 2'd0,
        ST_NOTFOUND  = 2'd1,
        ST_MALFORMED = 2'd2
    } search_status_t;

    typedef enum logic [4:0] {
        PH_TAG_FIRST = 5'b00001,
        PH_TAG_MORE  = 5'b00010,
        PH_LEN_FIRST = 5'b00100,
        PH_LEN_MORE  = 5'b01000,
        PH_VALUE     = 5'b10000
    } parse_phase_t;

endpackage

// ----- hw/rtl/ber_tlv_tag_search_unit.sv -----
// Top level of the BER-TLV tag search unit: input register, byte parser, result register.
// Depends on btts_pkg.
//
// The unit takes one byte of a flat BER-TLV list per cycle and walks the list element by
// element, counting elements whose tag (one byte, or the first two bytes of a multi-byte tag,
// big-endian) equals target_tag. It returns exactly one result per list: found with the start
// offset of the wanted_occurrence-th match (reported on the byte that completes that tag),
// malformed when a first length byte is 0x80 or 0x85 and above, or not found at the list's last
// byte (also at once on the first byte when wanted_occurrence is 0). After a result, bytes are
// dropped until the last byte, then the unit rearms. Throughput is one byte per cycle while no
// result waits, set by the single parse-state update per byte; a result is registered (the byte
// sits in the input register, and the result register loads when the parser takes that byte).
// While a result waits on m_ready the parser holds, and one further byte can sit in the input
// register. Configuration registers are written through the cfg_ channel, which is always
// ready; no clearing pass follows reset.
module ber_tlv_tag_search_unit
    import btts_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,

    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_INDEX_W-1:0]    cfg_index,
    input  logic [CFG_DATA_W-1:0]     cfg_data,

    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [7:0]                s_data_byte,
    input  logic                      s_last_byte,

    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [1:0]                m_status,
    output logic [MATCH_OFFSET_W-1:0] m_match_offset
);

    // configuration registers
    logic [TAG_W-1:0] target_tag_reg;
    logic [OCC_W-1:0] wanted_occurrence_reg;

    // input register
    logic       in_vld_reg;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;

    // parse state
    parse_phase_t         phase_reg,          phase_next;
    logic [TAG_W-1:0]     tag_value_reg,      tag_value_next;
    logic [2:0]           tag_count_reg,      tag_count_next;
    logic [2:0]           len_left_reg,       len_left_next;
    logic [VLEN_W-1:0]    value_left_reg,     value_left_next;
    logic [OFFSET_BITS-1:0] elem_start_reg,   elem_start_next;
    logic [OFFSET_BITS-1:0] byte_pos_reg,     byte_pos_next;
    logic [OCC_W-1:0]     matches_left_reg,   matches_left_next;
    logic                 search_done_reg,    search_done_next;
    logic                 list_open_reg,      list_open_next;

    // result register
    logic                      out_vld_reg;
    search_status_t            out_status_reg;
    logic [MATCH_OFFSET_W-1:0] out_offset_reg;

    // per-byte result
    logic                      emit;
    search_status_t            emit_status;
    logic [MATCH_OFFSET_W-1:0] emit_offset;
    logic                      tag_done;
    logic                      proc_fire;

    assign cfg_ready = 1'b1;

    // parser advances whenever a byte is held and the result register can take a new value
    assign proc_fire = in_vld_reg && (!out_vld_reg || m_ready);
    assign s_ready   = !in_vld_reg || proc_fire;

    assign m_valid        = out_vld_reg;
    assign m_status       = out_status_reg;
    assign m_match_offset = out_offset_reg;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_tag_reg        <= '0;
            wanted_occurrence_reg <= OCC_W'(1);
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_TARGET_TAG:        target_tag_reg        <= cfg_data[TAG_W-1:0];
                CFG_WANTED_OCCURRENCE: wanted_occurrence_reg <= cfg_data[OCC_W-1:0];
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_ready) begin
            in_vld_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_data_byte;
            in_last_reg <= s_last_byte;
        end
    end

    // byte parser: next state and result for the registered byte
    always_comb begin
        phase_next        = phase_reg;
        tag_value_next    = tag_value_reg;
        tag_count_next    = tag_count_reg;
        len_left_next     = len_left_reg;
        value_left_next   = value_left_reg;
        elem_start_next   = elem_start_reg;
        matches_left_next = list_open_reg ? matches_left_reg : wanted_occurrence_reg;
        search_done_next  = search_done_reg;
        list_open_next    = 1'b1;
        emit              = 1'b0;
        emit_status       = ST_NOTFOUND;
        emit_offset       = '0;
        tag_done          = 1'b0;

        // occurrence zero never matches
        if (!list_open_reg && wanted_occurrence_reg == '0) begin
            emit             = 1'b1;
            emit_status      = ST_NOTFOUND;
            search_done_next = 1'b1;
        end

        if (!search_done_next) begin
            unique case (phase_reg)
                PH_TAG_FIRST: begin
                    elem_start_next = byte_pos_reg;
                    tag_value_next  = {8'h00, in_byte_reg};
                    tag_count_next  = 3'd1;
                    if (in_byte_reg[4:0] == TAG_MULTI_BYTE) begin
                        phase_next = PH_TAG_MORE;
                    end else begin
                        tag_done = 1'b1;
                    end
                end
                PH_TAG_MORE: begin
                    if (tag_count_reg == 3'd1) begin
                        tag_value_next = {tag_value_reg[7:0], in_byte_reg};
                    end
                    if (tag_count_reg != 3'd7) begin
                        tag_count_next = tag_count_reg + 3'd1;
                    end
                    if (!in_byte_reg[7]) begin
                        tag_done = 1'b1;
                    end
                end
                PH_LEN_FIRST: begin
                    if (in_byte_reg < LEN_SHORT_LIMIT) begin
                        value_left_next = VLEN_W'(in_byte_reg);
                        phase_next = (in_byte_reg != 8'h00) ? PH_VALUE : PH_TAG_FIRST;
                    end else if (in_byte_reg >= LEN_LONG_MIN && in_byte_reg <= LEN_LONG_MAX) begin
                        len_left_next   = in_byte_reg[2:0];
                        value_left_next = '0;
                        phase_next      = PH_LEN_MORE;
                    end else begin
                        emit             = 1'b1;
                        emit_status      = ST_MALFORMED;
                        search_done_next = 1'b1;
                    end
                end
                PH_LEN_MORE: begin
                    value_left_next = {value_left_reg[VLEN_W-9:0], in_byte_reg};
                    len_left_next   = len_left_reg - 3'd1;
                    if (len_left_next == 3'd0) begin
                        phase_next = (value_left_next != '0) ? PH_VALUE : PH_TAG_FIRST;
                    end
                end
                PH_VALUE: begin
                    if (value_left_reg != '0) begin
                        value_left_next = value_left_reg - VLEN_W'(1);
                    end
                    if (value_left_next == '0) begin
                        phase_next = PH_TAG_FIRST;
                    end
                end
                default: phase_next = PH_TAG_FIRST;
            endcase
        end

        // completed tag: compare and count
        if (tag_done) begin
            phase_next = PH_LEN_FIRST;
            if (tag_value_next == target_tag_reg) begin
                matches_left_next = matches_left_next - OCC_W'(1);
                if (matches_left_next == '0) begin
                    emit             = 1'b1;
                    emit_status      = ST_FOUND;
                    emit_offset      = MATCH_OFFSET_W'(elem_start_next);
                    search_done_next = 1'b1;
                end
            end
        end

        byte_pos_next = byte_pos_reg + OFFSET_BITS'(1);

        // end of list: report not found if nothing yet, then rearm
        if (in_last_reg) begin
            if (!search_done_next) begin
                emit        = 1'b1;
                emit_status = ST_NOTFOUND;
                emit_offset = '0;
            end
            phase_next        = PH_TAG_FIRST;
            tag_value_next    = '0;
            tag_count_next    = '0;
            len_left_next     = '0;
            value_left_next   = '0;
            elem_start_next   = '0;
            byte_pos_next     = '0;
            matches_left_next = '0;
            search_done_next  = 1'b0;
            list_open_next    = 1'b0;
        end
    end

    // parse state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg        <= PH_TAG_FIRST;
            tag_value_reg    <= '0;
            tag_count_reg    <= '0;
            len_left_reg     <= '0;
            value_left_reg   <= '0;
            elem_start_reg   <= '0;
            byte_pos_reg     <= '0;
            matches_left_reg <= '0;
            search_done_reg  <= 1'b0;
            list_open_reg    <= 1'b0;
        end else if (proc_fire) begin
            phase_reg        <= phase_next;
            tag_value_reg    <= tag_value_next;
            tag_count_reg    <= tag_count_next;
            len_left_reg     <= len_left_next;
            value_left_reg   <= value_left_next;
            elem_start_reg   <= elem_start_next;
            byte_pos_reg     <= byte_pos_next;
            matches_left_reg <= matches_left_next;
            search_done_reg  <= search_done_next;
            list_open_reg    <= list_open_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (proc_fire && emit) begin
            out_vld_reg <= 1'b1;
        end else if (m_ready) begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (proc_fire && emit) begin
            out_status_reg <= emit_status;
            out_offset_reg <= emit_offset;
        end
    end

    // a result only carries an offset when found
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != ST_FOUND |-> m_match_offset == '0)
        else $error("non-found result carries an offset");

    // a finished search belongs to an open list
    assert property (@(posedge aclk) disable iff (!aresetn)
        search_done_reg |-> list_open_reg)
        else $error("search done outside an open list");

    // the last byte always rearms the parser
    assert property (@(posedge aclk) disable iff (!aresetn)
        proc_fire && in_last_reg |=> !list_open_reg && !search_done_reg
                                     && byte_pos_reg == '0)
        else $error("parser not rearmed after last byte");

    // long-form length bytes are pending whenever that phase is active
    assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_LEN_MORE |-> len_left_reg != 3'd0)
        else $error("length phase with no length bytes left");

    // a stalled result is never overwritten by the parser
    assert property (@(posedge aclk) disable iff (!aresetn)
        out_vld_reg && !m_ready |-> !proc_fire)
        else $error("parser advanced over a stalled result");

endmodule
